// ----- hw/rtl/sha256_pkg.sv -----
// SHA-256 stream hasher shared types, constants and round functions.
package sha256_pkg;

	localparam int BlockBytes = 64;
	localparam int LenFieldPos = 56;
	localparam int Rounds = 64;
	localparam int HashWords = 8;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_EMIT
	} ctrl_state_t;

	// datapath commands from the controller
	typedef struct packed {
		logic       write_byte;   // store byte at fill position
		logic [7:0] write_data;
		logic       write_len;    // write length byte at fill position
		logic       bump_fill;    // advance fill position
		logic       count_bits;   // message length += 8
		logic       round_start;  // load working vars from hash
		logic       round_step;   // run one round
		logic       hash_update;  // hash += working vars
		logic       hash_init;    // restart message
		logic       out_load;     // start digest output
		logic       out_next;     // shift digest output
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       rounds_done;
	} dp_stat_t;

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[idx];
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] h [8];
		h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
			32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
		return h[idx];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

// ----- hw/rtl/sha256_if.sv -----
// Valid/ready stream interfaces for the hasher input and digest output.
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] message_byte;
	logic       byte_valid;
	logic       message_end;
	modport source (output valid, message_byte, byte_valid, message_end, input ready);
	modport sink (input valid, message_byte, byte_valid, message_end, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        digest_last;
	modport source (output valid, digest_word, digest_last, input ready);
	modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// ----- hw/rtl/sha256_datapath.sv -----
// Block buffer, message schedule, round unit, hash state and digest shifter.
module sha256_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sha256_pkg::dp_cmd_t cmd,
	output sha256_pkg::dp_stat_t stat,
	output logic [31:0]         digest_word
);
	import sha256_pkg::*;

	logic [31:0] block_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] hash_q [HashWords];
	logic [31:0] work_q [HashWords];
	logic [31:0] sched_q [16];
	logic [5:0]  round_q;
	logic        done_q;
	logic [31:0] outsh_q [HashWords];

	logic [31:0] wr, s0, s1, m2, m15, e, a, t1, t2, ch, mj;
	logic [3:0]  slot;
	logic [2:0]  lsel;

	assign stat.fill = fill_q;
	assign stat.rounds_done = done_q;
	assign digest_word = outsh_q[0];
	assign slot = round_q[3:0];
	assign lsel = fill_q[2:0];

	// schedule word and round arithmetic
	always_comb begin
		m2  = sched_q[4'(slot - 4'd2)];
		m15 = sched_q[4'(slot - 4'd15)];
		s1 = rotr(m2, 17) ^ rotr(m2, 19) ^ (m2 >> 10);
		s0 = rotr(m15, 7) ^ rotr(m15, 18) ^ (m15 >> 3);
		if (round_q < 6'd16)
			wr = block_q[slot];
		else
			wr = s1 + sched_q[4'(slot - 4'd7)] + s0 + sched_q[slot];
		e = work_q[4];
		a = work_q[0];
		ch = (e & work_q[5]) ^ (~e & work_q[6]);
		mj = (a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1 = work_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + round_k(round_q) + wr;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.hash_init) begin
				fill_q <= '0;
				bits_q <= '0;
			end else begin
				if (cmd.bump_fill) fill_q <= fill_q + 6'd1;
				if (cmd.count_bits) bits_q <= bits_q + 64'd8;
			end
			if (cmd.round_start) begin
				round_q <= '0;
				done_q <= 1'b0;
			end else if (cmd.round_step) begin
				round_q <= round_q + 6'd1;
				done_q <= (round_q == 6'(Rounds - 1));
			end
		end
	end

	// hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HashWords; i++) hash_q[i] <= init_hash(3'(i));
		end else if (cmd.hash_init) begin
			for (int i = 0; i < HashWords; i++) hash_q[i] <= init_hash(3'(i));
		end else if (cmd.hash_update) begin
			for (int i = 0; i < HashWords; i++) hash_q[i] <= hash_q[i] + work_q[i];
		end
	end

	// block buffer (big-endian words), schedule, working variables, output shifter
	always_ff @(posedge clk) begin
		if (cmd.write_byte)
			block_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= cmd.write_data;
		else if (cmd.write_len)
			block_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= bits_q[{~lsel, 3'b000} +: 8];
		if (cmd.round_start) begin
			for (int i = 0; i < HashWords; i++) work_q[i] <= hash_q[i];
		end else if (cmd.round_step) begin
			sched_q[slot] <= wr;
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		// load takes the updated hash, issued alongside the final update
		if (cmd.out_load) begin
			for (int i = 0; i < HashWords; i++) outsh_q[i] <= hash_q[i] + work_q[i];
		end else if (cmd.out_next) begin
			for (int i = 0; i < HashWords - 1; i++) outsh_q[i] <= outsh_q[i + 1];
		end
	end
endmodule

// ----- hw/rtl/sha256_ctrl.sv -----
// Controller: byte intake, padding sequence, compression and digest output.
module sha256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           message_byte,
	input  logic                 byte_valid,
	input  logic                 message_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 digest_last,
	output sha256_pkg::dp_cmd_t  cmd,
	input  sha256_pkg::dp_stat_t stat
);
	import sha256_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        pad_q, pad_d;      // message ended: padding in progress
	logic        mark_q, mark_d;    // 0x80 marker already written
	logic        zero_q, zero_d;    // rest of this block is zero fill only
	logic        final_q, final_d;  // block under compression carries the length
	logic [2:0]  ocnt_q, ocnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pad_q <= 1'b0;
			mark_q <= 1'b0;
			zero_q <= 1'b0;
			final_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			state_q <= state_d;
			pad_q <= pad_d;
			mark_q <= mark_d;
			zero_q <= zero_d;
			final_q <= final_d;
			ocnt_q <= ocnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pad_d = pad_q;
		mark_d = mark_q;
		zero_d = zero_q;
		final_d = final_q;
		ocnt_d = ocnt_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		digest_last = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (byte_valid) begin
						cmd.write_byte = 1'b1;
						cmd.write_data = message_byte;
						cmd.bump_fill = 1'b1;
						cmd.count_bits = 1'b1;
					end
					pad_d = message_end;
					mark_d = 1'b0;
					zero_d = 1'b0;
					final_d = 1'b0;
					if (byte_valid && stat.fill == 6'(BlockBytes - 1)) begin
						cmd.round_start = 1'b1;
						state_d = ST_ROUND;
					end else if (message_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				// one byte a cycle: marker, zeros, then length bytes
				if (!mark_q) begin
					cmd.write_byte = 1'b1;
					cmd.write_data = 8'h80;
					mark_d = 1'b1;
					// marker in the length field pushes the length to a second block
					zero_d = (stat.fill >= 6'(LenFieldPos));
				end else if (!zero_q && stat.fill >= 6'(LenFieldPos)) begin
					cmd.write_len = 1'b1;
				end else begin
					cmd.write_byte = 1'b1;
					cmd.write_data = 8'h00;
				end
				cmd.bump_fill = 1'b1;
				if (stat.fill == 6'(BlockBytes - 1)) begin
					cmd.round_start = 1'b1;
					final_d = mark_q && !zero_q;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (stat.rounds_done)
					state_d = ST_UPDATE;
				else
					cmd.round_step = 1'b1;
			end
			ST_UPDATE: begin
				cmd.hash_update = 1'b1;
				if (final_q) begin
					cmd.out_load = 1'b1;
					ocnt_d = '0;
					state_d = ST_EMIT;
				end else if (pad_q) begin
					zero_d = 1'b0;
					state_d = ST_PAD;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				digest_last = (ocnt_q == 3'd7);
				if (out_ready) begin
					ocnt_d = ocnt_q + 3'd1;
					cmd.out_next = 1'b1;
					if (ocnt_q == 3'd7) begin
						cmd.hash_init = 1'b1;
						pad_d = 1'b0;
						mark_d = 1'b0;
						zero_d = 1'b0;
						final_d = 1'b0;
						state_d = ST_LOAD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end
endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: controller plus datapath.
//  channel   dir  payload                               handshake
//  in_word   in   message_byte, byte_valid, message_end  valid/ready
//  out_word  out  digest_word, digest_last               valid/ready
// One word is taken per cycle while loading; a full block is then compressed
// on the shared round unit and added into the hash before intake resumes.
// Ending a message pads one byte per cycle up to the block end, then compresses
// (twice when 56 or more bytes were pending), then shows eight digest words.
// in_word is not ready outside intake; out_word stalls hold the digest shifter.
// arst_n restarts with the initial hash.
module sha256_stream_hasher (
	input logic            clk,
	input logic            arst_n,
	sha256_in_if.sink      in_word,
	sha256_out_if.source   out_word
);
	import sha256_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha256_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_word.valid), .in_ready(in_word.ready),
		.message_byte(in_word.message_byte), .byte_valid(in_word.byte_valid),
		.message_end(in_word.message_end),
		.out_valid(out_word.valid), .out_ready(out_word.ready),
		.digest_last(out_word.digest_last),
		.cmd, .stat
	);

	sha256_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .digest_word(out_word.digest_word)
	);
endmodule

// ----- tb/sha256_digest_checker.sv -----
// Digest checker: watches both channels, predicts SHA-256 digests and compares.
`timescale 1ns / 1ps
module sha256_digest_checker (
	input logic         clk,
	input logic         arst_n,
	sha256_in_if        in_word,
	sha256_out_if       out_word,
	output int          fail_count,
	output int          pending_words
);
	import sha256_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_beat_t;

	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	logic [5:0]  fill;
	logic [63:0] bit_len;
	digest_beat_t digest_q [$];

	// Rotate helper kept local; round constants and initial hash come from the package
	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// One 64-round compression of blk into chain
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int r = 0; r < 16; r++)
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
				+ (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int r = 0; r < 64; r++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ round_k(r[5:0]) + w[r];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic restart();
		for (int i = 0; i < 8; i++) chain[i] = init_hash(i[2:0]);
		fill = '0;
		bit_len = '0;
	endtask

	// Absorb one input word; on end, pad and queue the eight digest words
	task automatic absorb(input logic [7:0] data, input logic has_byte, input logic fin);
		int p;
		digest_beat_t beat;
		if (has_byte) begin
			blk[fill] = data;
			fill++;
			bit_len += 64'd8;
			if (fill == 0) compress();
		end
		if (!fin) return;
		p = fill;
		blk[p++] = 8'h80;
		if (p > LenFieldPos) begin
			while (p < BlockBytes) blk[p++] = 8'h00;
			compress();
			p = 0;
		end
		while (p < LenFieldPos) blk[p++] = 8'h00;
		for (int i = 0; i < 8; i++) blk[LenFieldPos+i] = bit_len[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			beat.word = chain[i];
			beat.last = (i == 7);
			digest_q.push_back(beat);
		end
		restart();
	endtask

	initial begin
		restart();
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (in_word.valid && in_word.ready)
				absorb(in_word.message_byte, in_word.byte_valid, in_word.message_end);
			if (out_word.valid && out_word.ready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", out_word.digest_word);
					fail_count++;
				end else begin
					exp_beat = digest_q.pop_front();
					if (out_word.digest_word !== exp_beat.word) begin
						$error("digest_word expected %h actual %h",
							exp_beat.word, out_word.digest_word);
						fail_count++;
					end
					if (out_word.digest_last !== exp_beat.last) begin
						$error("digest_last expected %b actual %b",
							exp_beat.last, out_word.digest_last);
						fail_count++;
					end
				end
			end
		end
		pending_words = digest_q.size();
	end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives byte messages into the hasher and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_words;
	int   idle_cycles = 0;
	bit   calm;

	sha256_in_if  in_word ();
	sha256_out_if out_word ();

	sha256_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.out_word (out_word)
	);

	sha256_digest_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_word       (in_word),
		.out_word      (out_word),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Digest side back-pressure
	always @(negedge clk) begin
		out_word.ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
	end

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Send one word and wait for its acceptance; random gap first unless calm
	task automatic send(input logic [7:0] data, input logic has_byte, input logic fin);
		while (!calm && $urandom_range(99) < 32) begin
			in_word.valid <= 1'b0;
			@(negedge clk);
		end
		in_word.valid        <= 1'b1;
		in_word.message_byte <= data;
		in_word.byte_valid   <= has_byte;
		in_word.message_end  <= fin;
		do @(posedge clk); while (!in_word.ready);
		@(negedge clk);
	endtask

	// Message of len bytes (random, or all set to fixed when fixed >= 0), ending on the last byte or on a bare end word
	task automatic send_msg(input int len, input bit bare_end, input int fixed);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (fixed >= 0) ? fixed[7:0] : 8'($urandom_range(255));
			if ($urandom_range(9) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0);
			send(b, 1'b1, !bare_end && i == len - 1);
		end
		if (bare_end || len == 0) send(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	initial begin
		int len;
		calm = 1'b0;
		arst_n = 1'b0;
		in_word.valid = 1'b0;
		in_word.message_byte = '0;
		in_word.byte_valid = 1'b0;
		in_word.message_end = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		// Directed: empty message, idle word, extreme bytes, short messages
		send_msg(0, 1'b1, -1);
		send(8'hff, 1'b0, 1'b0);
		send_msg(1, 1'b0, 0);
		send_msg(1, 1'b0, 255);
		send_msg(3, 1'b1, 8'hff);
		send_msg(2, 1'b0, -1);
		// Random messages: short ones, then around the one- and two-block boundaries
		for (int m = 0; m < 4; m++) begin
			calm = (m == 2);
			case (m)
				0: len = $urandom_range(8);
				1: len = $urandom_range(54, 57);
				2: len = $urandom_range(62, 65);
				default: len = $urandom_range(119, 121);
			endcase
			send_msg(len, $urandom_range(1), -1);
		end
		in_word.valid <= 1'b0;
		calm = 1'b0;
		wait (pending_words == 0);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
